### src/assert_macros.svh
// Assertion macros used by the RTL of the status LED controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that a consequence holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

### src/slsc_pkg.sv
// Constants, codes and helper functions of the status LED controller.
package slsc_pkg;

  localparam int LEVEL_W = 8;
  localparam int EVENT_W = 4;
  localparam int MODE_W = 3;
  localparam int NOTIFY_W = 2;
  localparam int PHASE_W = 5;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [LEVEL_W-1:0] OK_GREEN_RESET = 8'd80;
  localparam logic [LEVEL_W-1:0] DUTY_FULL = 8'd255;
  localparam logic [PHASE_W-1:0] PHASE_LAST = 5'd19;
  localparam logic [PHASE_W-1:0] PHASE_HALF = 5'd10;
  localparam logic [PHASE_W-1:0] PHASE_PERIOD = 5'd20;
  localparam logic [PHASE_W-1:0] PULSE_ON = 5'd5;
  localparam logic [PHASE_W-1:0] PULSE_SECOND_OFF = 5'd15;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OK = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WARN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ALERT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CRITICAL = 3'd4;

  localparam logic [NOTIFY_W-1:0] NOTIFY_NONE = 2'd0;
  localparam logic [NOTIFY_W-1:0] NOTIFY_ALERT = 2'd1;
  localparam logic [NOTIFY_W-1:0] NOTIFY_CRITICAL = 2'd2;
  localparam logic [NOTIFY_W-1:0] NOTIFY_OK = 2'd3;

  localparam logic [EVENT_W-1:0] EV_HANDSET_UP = 4'd0;
  localparam logic [EVENT_W-1:0] EV_HANDSET_BACK = 4'd1;
  localparam logic [EVENT_W-1:0] EV_HANDSET_LATE = 4'd2;
  localparam logic [EVENT_W-1:0] EV_HANDSET_LOST = 4'd3;
  localparam logic [EVENT_W-1:0] EV_GW_OK = 4'd4;
  localparam logic [EVENT_W-1:0] EV_GW_STALE = 4'd5;
  localparam logic [EVENT_W-1:0] EV_GW_UNREACHABLE = 4'd6;
  localparam logic [EVENT_W-1:0] EV_BATT_LOW = 4'd7;
  localparam logic [EVENT_W-1:0] EV_BATT_OK = 4'd8;
  localparam logic [EVENT_W-1:0] EV_USB_LOST = 4'd9;
  localparam logic [EVENT_W-1:0] EV_USB_RESTORED = 4'd10;
  localparam logic [EVENT_W-1:0] EV_WIFI_UP = 4'd11;
  localparam logic [EVENT_W-1:0] EV_WIFI_DOWN = 4'd12;

  typedef struct packed {
    logic phone_healthy;
    logic gateway_healthy;
    logic battery_low;
    logic usb_missing;
    logic wifi_up;
  } flags_t;

  function automatic logic [MODE_W-1:0] derive_mode(input flags_t f);
    logic [MODE_W-1:0] m;
    if (!f.wifi_up) begin
      m = MODE_IDLE;
    end else if (f.battery_low || (f.usb_missing && !f.phone_healthy)) begin
      m = MODE_CRITICAL;
    end else if (!f.phone_healthy || !f.gateway_healthy) begin
      m = MODE_ALERT;
    end else if (f.usb_missing) begin
      m = MODE_WARN;
    end else begin
      m = MODE_OK;
    end
    return m;
  endfunction

  function automatic logic [LEVEL_W-1:0] half_breathe(input logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] k;
    logic [LEVEL_W-1:0] full;
    k = (p < PHASE_HALF) ? p : PHASE_PERIOD - p;
    full = LEVEL_W'(k) * LEVEL_W'(25);
    return full >> 1;
  endfunction

endpackage

### src/status_led_state_controller.sv
// Status LED state controller: health flags, state derivation and RGB rendering.
//
// A new input word is accepted in every cycle unless the input side stalls. A render tick
// in the input register has its result word written into the output register. A status
// event updates the flags and produces no result word. The input side stalls only when a
// render tick waits in the input register while the output register still holds a word
// that has not been taken.
// The green level is written over the cfg channel, which is always ready.
`include "assert_macros.svh"

module status_led_state_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slsc_pkg::LEVEL_W-1:0]      cfg_data,    // ok_green_level
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [slsc_pkg::IN_DATA_W-1:0]    in_tdata,    // event_code[3:0], zero pad
  input  logic                              in_tuser,    // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // red_duty[7:0], green_duty[15:8], blue_duty[23:16], system_state[26:24],
  // notify[28:27], zero pad
  output logic [slsc_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import slsc_pkg::*;

  logic                  in_valid_r;
  logic                  cmd_r;
  logic [EVENT_W-1:0]    event_r;
  flags_t                flags_r, flags_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic [LEVEL_W-1:0]    green_level_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  advance;
  logic                  load_out;
  logic                  pulse;
  logic [LEVEL_W-1:0]    breathe;
  logic [LEVEL_W-1:0]    red, green, blue;
  logic [NOTIFY_W-1:0]   notify;

  assign advance   = in_valid_r && (cmd_r == CMD_EVENT || !out_valid_r || out_tready);
  assign load_out  = advance && cmd_r == CMD_TICK;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    flags_nxt = flags_r;
    if (advance && cmd_r == CMD_EVENT) begin
      case (event_r)
        EV_HANDSET_UP, EV_HANDSET_BACK:       flags_nxt.phone_healthy = 1'b1;
        EV_HANDSET_LOST:                      flags_nxt.phone_healthy = 1'b0;
        EV_GW_OK:                             flags_nxt.gateway_healthy = 1'b1;
        EV_GW_STALE, EV_GW_UNREACHABLE:       flags_nxt.gateway_healthy = 1'b0;
        EV_BATT_LOW:                          flags_nxt.battery_low = 1'b1;
        EV_BATT_OK:                           flags_nxt.battery_low = 1'b0;
        EV_USB_LOST:                          flags_nxt.usb_missing = 1'b1;
        EV_USB_RESTORED:                      flags_nxt.usb_missing = 1'b0;
        EV_WIFI_UP:                           flags_nxt.wifi_up = 1'b1;
        EV_WIFI_DOWN:                         flags_nxt.wifi_up = 1'b0;
        default:                              flags_nxt = flags_r;
      endcase
    end
  end

  always_comb begin
    mode_nxt = derive_mode(flags_r);
    notify = NOTIFY_NONE;
    if (mode_nxt != mode_r) begin
      case (mode_nxt)
        MODE_ALERT:    notify = NOTIFY_ALERT;
        MODE_CRITICAL: notify = NOTIFY_CRITICAL;
        MODE_OK:       notify = NOTIFY_OK;
        default:       notify = NOTIFY_NONE;
      endcase
    end
    pulse = (phase_r < PULSE_ON) || (phase_r >= PHASE_HALF && phase_r < PULSE_SECOND_OFF);
    breathe = half_breathe(phase_r);
    red = '0;
    green = '0;
    blue = '0;
    case (mode_nxt)
      MODE_IDLE:  blue = pulse ? DUTY_FULL : '0;
      MODE_OK:    green = green_level_r;
      MODE_WARN: begin
        red = breathe;
        green = breathe;
      end
      MODE_ALERT: red = pulse ? DUTY_FULL : '0;
      default:    red = DUTY_FULL;
    endcase
    out_data_nxt = {3'b000, notify, mode_nxt, blue, green, red};
    phase_nxt = (phase_r == PHASE_LAST) ? '0 : phase_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      flags_r       <= '0;
      mode_r        <= MODE_IDLE;
      phase_r       <= '0;
      green_level_r <= OK_GREEN_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      flags_r <= flags_nxt;
      if (load_out) begin
        mode_r  <= mode_nxt;
        phase_r <= phase_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        green_level_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      cmd_r   <= in_tuser;
      event_r <= in_tdata[EVENT_W-1:0];
    end
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_ALWAYS(a_phase_range, clk, rst_n, phase_r < PHASE_PERIOD)
  `ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_tready,
               in_valid_r && cmd_r == CMD_TICK && out_valid_r && !out_tready)
  `ASSERT_NEXT(a_state_tracks, clk, rst_n, load_out,
               out_tvalid && out_tdata[26:24] == mode_r)
  `ASSERT_IMPL(a_notify_match, clk, rst_n, out_tvalid && out_tdata[28:27] == NOTIFY_OK,
               out_tdata[26:24] == MODE_OK)

endmodule
